/* hdl/assert_macros.svh */
// Assertion helpers used by the checker file.
// Include guard keeps repeated inclusion harmless.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define GHA_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("gha assertion failed");

// Next-cycle implication, disabled while reset is high.
`define GHA_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("gha assertion failed");

`endif

/* hdl/gha_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gha_pkg
// Field widths, command codes and status codes of the handle allocator.
// ---------------------------------------------------------------------------
package gha_pkg;

   localparam int CMD_W    = 3;
   localparam int INDEX_W  = 10;
   localparam int GEN_W    = 16;
   localparam int STATUS_W = 3;
   localparam int LIVE_W   = 11;

   localparam logic [CMD_W-1:0] CMD_CREATE  = 3'd0;
   localparam logic [CMD_W-1:0] CMD_DESTROY = 3'd1;
   localparam logic [CMD_W-1:0] CMD_QUERY   = 3'd2;
   localparam logic [CMD_W-1:0] CMD_BEGIN   = 3'd3;
   localparam logic [CMD_W-1:0] CMD_END     = 3'd4;

   localparam logic [STATUS_W-1:0] ST_DONE     = 3'd0;
   localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
   localparam logic [STATUS_W-1:0] ST_DEFERRED = 3'd2;
   localparam logic [STATUS_W-1:0] ST_STALE    = 3'd3;
   localparam logic [STATUS_W-1:0] ST_QFULL    = 3'd4;

endpackage

/* hdl/gha_req_if.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gha_req_if
// Request channel: valid/ready handshake carrying one command.
// ---------------------------------------------------------------------------
interface gha_req_if;
   logic                        valid;
   logic                        ready;
   logic [gha_pkg::CMD_W-1:0]   cmd;
   logic [gha_pkg::INDEX_W-1:0] handle_index;
   logic [gha_pkg::GEN_W-1:0]   handle_generation;

   modport source (output valid, output cmd, output handle_index,
                   output handle_generation, input ready);
   modport sink (input valid, input cmd, input handle_index,
                 input handle_generation, output ready);
endinterface

/* hdl/gha_rsp_if.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gha_rsp_if
// Response channel: valid/ready handshake carrying one result.
// ---------------------------------------------------------------------------
interface gha_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [gha_pkg::INDEX_W-1:0]  out_index;
   logic [gha_pkg::GEN_W-1:0]    out_generation;
   logic                         alive;
   logic [gha_pkg::STATUS_W-1:0] status;
   logic [gha_pkg::LIVE_W-1:0]   live_count;

   modport source (output valid, output out_index, output out_generation,
                   output alive, output status, output live_count, input ready);
   modport sink (input valid, input out_index, input out_generation,
                 input alive, input status, input live_count, output ready);
endinterface

/* hdl/gha_entity_table.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gha_entity_table
// Per-index alive bit and generation in one synchronous memory, with the
// generation compare and the bumped generation taken off the read data.
// ---------------------------------------------------------------------------
module gha_entity_table #(
   parameter int DEPTH    = 1024,
   parameter int ADDR_W   = 10,
   parameter int GEN_BITS = 16
) (
   input  logic                clock,
   input  logic                rd_en,
   input  logic [ADDR_W-1:0]   rd_addr,
   input  logic                wr_en,
   input  logic [ADDR_W-1:0]   wr_addr,
   input  logic                wr_alive,
   input  logic [GEN_BITS-1:0] wr_gen,
   input  logic [GEN_BITS-1:0] chk_gen,
   output logic                rd_alive,
   output logic [GEN_BITS-1:0] rd_gen,
   output logic                gen_match,
   output logic [GEN_BITS-1:0] gen_bumped
);

   logic [GEN_BITS:0] mem [DEPTH];
   logic [GEN_BITS:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= {wr_alive, wr_gen};
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_alive   = rd_data_ff[GEN_BITS];
   assign rd_gen     = rd_data_ff[GEN_BITS-1:0];
   assign gen_match  = (rd_gen == chk_gen);
   // generation wraps at GEN_BITS
   assign gen_bumped = rd_gen + 1'b1;

endmodule

/* hdl/generational_handle_allocator.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// generational_handle_allocator
// Entity handle allocator with LIFO index reuse and deferred destroys.
// ---------------------------------------------------------------------------
// One request is worked at a time. Query, destroy, begin iteration, create
// of a fresh index and end of iteration with an empty queue are answered from
// the execute state; create that reuses a freed index reads the free stack,
// then the entity table. End of iteration with N queued destroys handles each
// queued entry as a queue read, an entity table read and a write-back.
// A finished response sits in an output register, so the next request is
// accepted while it waits. The high-water mark bounds which table entries
// were ever written, so no clearing pass runs after reset.
module generational_handle_allocator #(
   parameter int MAX_ENTITIES  = 1024,
   parameter int GEN_BITS      = 16,
   parameter int PENDING_DEPTH = 64
) (
   input  logic       clock,
   input  logic       reset,
   gha_req_if.sink    req_chan,
   gha_rsp_if.source  rsp_chan
);

   localparam int IDX_W = $clog2(MAX_ENTITIES);
   localparam int CNT_W = $clog2(MAX_ENTITIES + 1);
   localparam int PQ_AW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
   localparam int PQ_CW = $clog2(PENDING_DEPTH + 1);
   localparam int CMP_W = (CNT_W > gha_pkg::INDEX_W) ? CNT_W : gha_pkg::INDEX_W;
   localparam int PQ_W  = gha_pkg::INDEX_W + gha_pkg::GEN_W;

   localparam logic [2:0] S_IDLE      = 3'd0;
   localparam logic [2:0] S_EXEC      = 3'd1;
   localparam logic [2:0] S_POP       = 3'd2;
   localparam logic [2:0] S_DRAIN_RD  = 3'd3;
   localparam logic [2:0] S_DRAIN_ENT = 3'd4;
   localparam logic [2:0] S_DRAIN_WR  = 3'd5;
   localparam logic [2:0] S_FINAL_RD  = 3'd6;
   localparam logic [2:0] S_FINAL     = 3'd7;

   logic [2:0]                   state_ff, state_in;
   logic [gha_pkg::CMD_W-1:0]    cmd_ff, cmd_in;
   logic [gha_pkg::INDEX_W-1:0]  idx_ff, idx_in;
   logic [gha_pkg::GEN_W-1:0]    gen_ff, gen_in;
   logic [CNT_W-1:0]             hw_ff, hw_in;
   logic [CNT_W-1:0]             ft_ff, ft_in;
   logic                         iter_ff, iter_in;
   logic [PQ_CW-1:0]             pc_ff, pc_in;
   logic [PQ_CW-1:0]             dptr_ff, dptr_in;
   logic [IDX_W-1:0]             pop_idx_ff, pop_idx_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rsp_load;
   logic [gha_pkg::INDEX_W-1:0]  rsp_index_ff, res_index;
   logic [gha_pkg::GEN_W-1:0]    rsp_gen_ff, res_gen;
   logic                         rsp_alive_ff, res_alive;
   logic [gha_pkg::STATUS_W-1:0] rsp_status_ff, res_status;
   logic [gha_pkg::LIVE_W-1:0]   rsp_live_ff, res_live;

   // entity table port
   logic                ent_re, ent_we, ent_walive;
   logic [IDX_W-1:0]    ent_ra, ent_wa;
   logic [GEN_BITS-1:0] ent_wgen, chk_gen;
   logic                ent_rd_alive, gen_match;
   logic [GEN_BITS-1:0] ent_rd_gen, gen_bumped;

   // free stack
   logic [IDX_W-1:0] fs_mem [MAX_ENTITIES];
   logic [IDX_W-1:0] fs_rd_ff;
   logic             fs_re, fs_we;
   logic [IDX_W-1:0] fs_ra, fs_wa, fs_wd;

   // pending destroy queue
   logic [PQ_W-1:0]  pq_mem [PENDING_DEPTH];
   logic [PQ_W-1:0]  pq_rd_ff;
   logic             pq_re, pq_we;
   logic [PQ_AW-1:0] pq_ra, pq_wa;
   logic [gha_pkg::INDEX_W-1:0] pq_idx;
   logic [gha_pkg::GEN_W-1:0]   pq_gen;

   logic out_free;
   logic live_now;
   logic drain_live;

   gha_entity_table #(
      .DEPTH    (MAX_ENTITIES),
      .ADDR_W   (IDX_W),
      .GEN_BITS (GEN_BITS)
   ) u_ent (
      .clock      (clock),
      .rd_en      (ent_re),
      .rd_addr    (ent_ra),
      .wr_en      (ent_we),
      .wr_addr    (ent_wa),
      .wr_alive   (ent_walive),
      .wr_gen     (ent_wgen),
      .chk_gen    (chk_gen),
      .rd_alive   (ent_rd_alive),
      .rd_gen     (ent_rd_gen),
      .gen_match  (gen_match),
      .gen_bumped (gen_bumped)
   );

   always_ff @(posedge clock) begin
      if (fs_we) begin
         fs_mem[fs_wa] <= fs_wd;
      end
      if (fs_re) begin
         fs_rd_ff <= fs_mem[fs_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (pq_we) begin
         pq_mem[pq_wa] <= {idx_ff, gen_ff};
      end
      if (pq_re) begin
         pq_rd_ff <= pq_mem[pq_ra];
      end
   end

   assign pq_idx = pq_rd_ff[PQ_W-1 -: gha_pkg::INDEX_W];
   assign pq_gen = pq_rd_ff[gha_pkg::GEN_W-1:0];

   assign out_free   = !rsp_valid_ff || rsp_chan.ready;
   assign live_now   = (CMP_W'(idx_ff) < CMP_W'(hw_ff)) && ent_rd_alive && gen_match;
   assign drain_live = (CMP_W'(pq_idx) < CMP_W'(hw_ff)) && ent_rd_alive && gen_match;

   always_comb begin
      state_in   = state_ff;
      cmd_in     = cmd_ff;
      idx_in     = idx_ff;
      gen_in     = gen_ff;
      hw_in      = hw_ff;
      ft_in      = ft_ff;
      iter_in    = iter_ff;
      pc_in      = pc_ff;
      dptr_in    = dptr_ff;
      pop_idx_in = pop_idx_ff;

      ent_re     = 1'b0;
      ent_ra     = IDX_W'(idx_ff);
      ent_we     = 1'b0;
      ent_wa     = IDX_W'(idx_ff);
      ent_walive = 1'b0;
      ent_wgen   = gen_bumped;
      chk_gen    = GEN_BITS'(gen_ff);
      fs_re      = 1'b0;
      fs_ra      = IDX_W'(ft_ff - 1'b1);
      fs_we      = 1'b0;
      fs_wa      = IDX_W'(ft_ff);
      fs_wd      = IDX_W'(idx_ff);
      pq_re      = 1'b0;
      pq_ra      = PQ_AW'(dptr_ff);
      pq_we      = 1'b0;
      pq_wa      = PQ_AW'(pc_ff);

      rsp_load   = 1'b0;
      res_index  = idx_ff;
      res_gen    = gen_ff;
      res_alive  = live_now;
      res_status = gha_pkg::ST_DONE;

      case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               cmd_in   = req_chan.cmd;
               idx_in   = req_chan.handle_index;
               gen_in   = req_chan.handle_generation;
               ent_re   = 1'b1;
               ent_ra   = IDX_W'(req_chan.handle_index);
               fs_re    = 1'b1;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (out_free) begin
               state_in = S_IDLE;
               case (cmd_ff)
                  gha_pkg::CMD_CREATE: begin
                     if (ft_ff != '0) begin
                        // reuse the most recently freed index
                        ft_in      = ft_ff - 1'b1;
                        pop_idx_in = fs_rd_ff;
                        ent_re     = 1'b1;
                        ent_ra     = fs_rd_ff;
                        state_in   = S_POP;
                     end else if (hw_ff < MAX_ENTITIES) begin
                        // fresh entry: never written, so generation is zero
                        ent_we     = 1'b1;
                        ent_wa     = IDX_W'(hw_ff);
                        ent_walive = 1'b1;
                        ent_wgen   = '0;
                        hw_in      = hw_ff + 1'b1;
                        rsp_load   = 1'b1;
                        res_index  = gha_pkg::INDEX_W'(hw_ff);
                        res_gen    = '0;
                        res_alive  = 1'b1;
                     end else begin
                        rsp_load   = 1'b1;
                        res_status = gha_pkg::ST_FULL;
                     end
                  end
                  gha_pkg::CMD_DESTROY: begin
                     rsp_load = 1'b1;
                     if (!live_now) begin
                        res_status = gha_pkg::ST_STALE;
                     end else if (iter_ff) begin
                        if (pc_ff < PENDING_DEPTH) begin
                           pq_we      = 1'b1;
                           pc_in      = pc_ff + 1'b1;
                           res_status = gha_pkg::ST_DEFERRED;
                        end else begin
                           res_status = gha_pkg::ST_QFULL;
                        end
                     end else begin
                        ent_we    = 1'b1;
                        fs_we     = 1'b1;
                        ft_in     = ft_ff + 1'b1;
                        res_alive = 1'b0;
                     end
                  end
                  gha_pkg::CMD_BEGIN: begin
                     iter_in  = 1'b1;
                     rsp_load = 1'b1;
                  end
                  gha_pkg::CMD_END: begin
                     iter_in = 1'b0;
                     if (pc_ff != '0) begin
                        dptr_in  = '0;
                        state_in = S_DRAIN_RD;
                     end else begin
                        rsp_load = 1'b1;
                     end
                  end
                  default: begin
                     rsp_load = 1'b1;
                  end
               endcase
            end
         end
         S_POP: begin
            if (out_free) begin
               ent_we     = 1'b1;
               ent_wa     = pop_idx_ff;
               ent_walive = 1'b1;
               ent_wgen   = ent_rd_gen;
               rsp_load   = 1'b1;
               res_index  = gha_pkg::INDEX_W'(pop_idx_ff);
               res_gen    = gha_pkg::GEN_W'(ent_rd_gen);
               res_alive  = 1'b1;
               state_in   = S_IDLE;
            end
         end
         S_DRAIN_RD: begin
            pq_re    = 1'b1;
            state_in = S_DRAIN_ENT;
         end
         S_DRAIN_ENT: begin
            ent_re   = 1'b1;
            ent_ra   = IDX_W'(pq_idx);
            state_in = S_DRAIN_WR;
         end
         S_DRAIN_WR: begin
            chk_gen = GEN_BITS'(pq_gen);
            ent_wa  = IDX_W'(pq_idx);
            fs_wd   = IDX_W'(pq_idx);
            // queued handle may have gone stale; then it is skipped
            if (drain_live) begin
               ent_we = 1'b1;
               fs_we  = 1'b1;
               ft_in  = ft_ff + 1'b1;
            end
            dptr_in = dptr_ff + 1'b1;
            if (dptr_in == pc_ff) begin
               pc_in    = '0;
               state_in = S_FINAL_RD;
            end else begin
               state_in = S_DRAIN_RD;
            end
         end
         S_FINAL_RD: begin
            ent_re   = 1'b1;
            state_in = S_FINAL;
         end
         S_FINAL: begin
            if (out_free) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      res_live     = gha_pkg::LIVE_W'(hw_in - ft_in);
      rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_chan.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         hw_ff        <= '0;
         ft_ff        <= '0;
         iter_ff      <= 1'b0;
         pc_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         hw_ff        <= hw_in;
         ft_ff        <= ft_in;
         iter_ff      <= iter_in;
         pc_ff        <= pc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff     <= cmd_in;
      idx_ff     <= idx_in;
      gen_ff     <= gen_in;
      dptr_ff    <= dptr_in;
      pop_idx_ff <= pop_idx_in;
      if (rsp_load) begin
         rsp_index_ff  <= res_index;
         rsp_gen_ff    <= res_gen;
         rsp_alive_ff  <= res_alive;
         rsp_status_ff <= res_status;
         rsp_live_ff   <= res_live;
      end
   end

   assign req_chan.ready          = (state_ff == S_IDLE);
   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.out_index      = rsp_index_ff;
   assign rsp_chan.out_generation = rsp_gen_ff;
   assign rsp_chan.alive          = rsp_alive_ff;
   assign rsp_chan.status         = rsp_status_ff;
   assign rsp_chan.live_count     = rsp_live_ff;

endmodule

/* hdl/gha_checker.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gha_checker
// Port-level checks on the allocator's responses, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module gha_checker #(
   parameter int MAX_ENTITIES = 1024
) (
   input logic                         clock,
   input logic                         reset,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic                         rsp_alive,
   input logic [gha_pkg::STATUS_W-1:0] rsp_status,
   input logic [gha_pkg::LIVE_W-1:0]   rsp_live_count
);

   localparam logic [gha_pkg::LIVE_W-1:0] FULL_COUNT = gha_pkg::LIVE_W'(MAX_ENTITIES);

   // a response is held until taken
   `GHA_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)

   // an ignored stale destroy never reports a live handle
   `GHA_ASSERT_IMP(a_stale_dead, clock, reset,
                   rsp_valid && rsp_status == gha_pkg::ST_STALE, !rsp_alive)

   // a deferred or dropped destroy leaves the handle live
   `GHA_ASSERT_IMP(a_defer_live, clock, reset,
                   rsp_valid && (rsp_status == gha_pkg::ST_DEFERRED ||
                   rsp_status == gha_pkg::ST_QFULL), rsp_alive)

   // table full only when every index is live
   `GHA_ASSERT_IMP(a_full_count, clock, reset,
                   rsp_valid && rsp_status == gha_pkg::ST_FULL, rsp_live_count == FULL_COUNT)

endmodule

bind generational_handle_allocator gha_checker #(
   .MAX_ENTITIES (MAX_ENTITIES)
) u_gha_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_alive      (rsp_chan.alive),
   .rsp_status     (rsp_chan.status),
   .rsp_live_count (rsp_chan.live_count)
);

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the generational handle allocator. Commands go in
// through the request channel and every response is checked field by field
// against a cycle-free model of the entity table, free stack and deferred
// destroy queue. A directed opening covers reuse, stale handles and windows;
// random phases vary idling, one run fills the table and overflows the queue.
// ---------------------------------------------------------------------------
module tb_top;

   localparam int MAX_ENT     = 1024;
   localparam int PEND_DEPTH  = 64;
   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_LEN    = 400;

   // codes the block must treat as no-ops
   localparam logic [gha_pkg::CMD_W-1:0] CMD_RSVD_FIRST = gha_pkg::CMD_END + 3'd1;
   localparam logic [gha_pkg::CMD_W-1:0] CMD_RSVD_LAST  = '1;

   typedef struct packed {
      logic [gha_pkg::INDEX_W-1:0]  idx;
      logic [gha_pkg::GEN_W-1:0]    gen;
      logic                         alive;
      logic [gha_pkg::STATUS_W-1:0] status;
      logic [gha_pkg::LIVE_W-1:0]   live;
   } handle_answer_type;

   class handle_checker;
      bit                          alive_tab [MAX_ENT];
      bit [gha_pkg::GEN_W-1:0]     gen_tab [MAX_ENT];
      bit [gha_pkg::INDEX_W-1:0]   free_stack [MAX_ENT];
      bit [gha_pkg::INDEX_W-1:0]   defer_idx [PEND_DEPTH];
      bit [gha_pkg::GEN_W-1:0]     defer_gen [PEND_DEPTH];
      int                          high_water;
      int                          free_top;
      int                          defer_count;
      bit                          iterating;
      handle_answer_type           awaited_answers [$];
      int                          bad_answers;

      function bit is_live(bit [gha_pkg::INDEX_W-1:0] i, bit [gha_pkg::GEN_W-1:0] g);
         return (i < high_water) && alive_tab[i] && (gen_tab[i] == g);
      endfunction

      function void retire(bit [gha_pkg::INDEX_W-1:0] i, bit [gha_pkg::GEN_W-1:0] g);
         if (is_live(i, g)) begin
            alive_tab[i] = 1'b0;
            gen_tab[i]   = gen_tab[i] + 1'b1;
            if (free_top < MAX_ENT) begin
               free_stack[free_top] = i;
               free_top++;
            end
         end
      endfunction

      // Advances the table for one accepted request and queues its answer.
      function void accept_command(logic [gha_pkg::CMD_W-1:0] c,
                                   logic [gha_pkg::INDEX_W-1:0] i_in,
                                   logic [gha_pkg::GEN_W-1:0] g_in);
         handle_answer_type            ans;
         bit [gha_pkg::INDEX_W-1:0]    i;
         bit [gha_pkg::GEN_W-1:0]      g;
         bit [gha_pkg::STATUS_W-1:0]   st;
         i  = i_in;
         g  = g_in;
         st = gha_pkg::ST_DONE;
         case (c)
            gha_pkg::CMD_CREATE: begin
               if (free_top > 0) begin
                  free_top--;
                  i = free_stack[free_top];
               end else if (high_water < MAX_ENT) begin
                  i = gha_pkg::INDEX_W'(high_water);
                  high_water++;
               end else begin
                  st = gha_pkg::ST_FULL;
               end
               if (st == gha_pkg::ST_DONE) begin
                  alive_tab[i] = 1'b1;
                  g = gen_tab[i];
               end
            end
            gha_pkg::CMD_DESTROY: begin
               if (!is_live(i, g)) begin
                  st = gha_pkg::ST_STALE;
               end else if (iterating) begin
                  if (defer_count < PEND_DEPTH) begin
                     defer_idx[defer_count] = i;
                     defer_gen[defer_count] = g;
                     defer_count++;
                     st = gha_pkg::ST_DEFERRED;
                  end else begin
                     st = gha_pkg::ST_QFULL;
                  end
               end else begin
                  retire(i, g);
               end
            end
            gha_pkg::CMD_BEGIN: iterating = 1'b1;
            gha_pkg::CMD_END: begin
               iterating = 1'b0;
               for (int k = 0; k < defer_count; k++)
                  retire(defer_idx[k], defer_gen[k]);
               defer_count = 0;
            end
            default: ;
         endcase
         ans.idx    = i;
         ans.gen    = g;
         ans.alive  = is_live(i, g);
         ans.status = st;
         ans.live   = gha_pkg::LIVE_W'(high_water - free_top);
         awaited_answers.insert(awaited_answers.size(), ans);
      endfunction

      function void check_answer(handle_answer_type got);
         handle_answer_type want;
         if (awaited_answers.size() == 0) begin
            bad_answers++;
            if (bad_answers <= 10)
               $display("unexpected response: idx %0d gen %0d alive %0b st %0d live %0d",
                        got.idx, got.gen, got.alive, got.status, got.live);
            return;
         end
         want = awaited_answers.pop_front();
         if (got !== want) begin
            bad_answers++;
            if (bad_answers <= 10) begin
               $display("mismatch: want idx %0d gen %0d alive %0b st %0d live %0d",
                        want.idx, want.gen, want.alive, want.status, want.live);
               $display("          got  idx %0d gen %0d alive %0b st %0d live %0d",
                        got.idx, got.gen, got.alive, got.status, got.live);
            end
         end
      endfunction

      // Mostly current handles, some one generation behind, some arbitrary.
      function void pick_handle(output logic [gha_pkg::INDEX_W-1:0] i,
                                output logic [gha_pkg::GEN_W-1:0] g);
         int sel;
         sel = $urandom_range(99);
         if (high_water > 0 && sel < 85) begin
            i = gha_pkg::INDEX_W'($urandom_range(high_water - 1));
            g = (sel < 70) ? gen_tab[i] : gen_tab[i] - 1'b1;
         end else begin
            i = gha_pkg::INDEX_W'($urandom);
            g = gha_pkg::GEN_W'($urandom);
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   gha_req_if req_if ();
   gha_rsp_if rsp_if ();

   generational_handle_allocator #(
      .MAX_ENTITIES (MAX_ENT),
      .GEN_BITS     (gha_pkg::GEN_W),
      .PENDING_DEPTH(PEND_DEPTH)
   ) u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_if.sink),
      .rsp_chan(rsp_if.source)
   );

   handle_checker sb;
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int hold_left     = 0;
   int hold_reqs     = 0;
   int hold_seen     = 0;

   always #1 clock = ~clock;

   // response side: check, then pick ready for the next edge
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready)
         sb.check_answer({rsp_if.out_index, rsp_if.out_generation, rsp_if.alive,
                          rsp_if.status, rsp_if.live_count});
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else if (hold_reqs != hold_seen) begin
         // long hold-off counted here
         hold_seen    <= hold_reqs;
         hold_left    <= HOLD_LEN - 1;
         rsp_if.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left    <= hold_left - 1;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   task automatic send_request(input logic [gha_pkg::CMD_W-1:0] c,
                               input logic [gha_pkg::INDEX_W-1:0] i,
                               input logic [gha_pkg::GEN_W-1:0] g);
      if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_if.valid             <= 1'b1;
      req_if.cmd               <= c;
      req_if.handle_index      <= i;
      req_if.handle_generation <= g;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      sb.accept_command(c, i, g);
   endtask

   // sender pause: nothing offered until every response is back
   task automatic drain_responses();
      req_if.valid <= 1'b0;
      while (sb.awaited_answers.size() != 0) @(posedge clock);
   endtask

   task automatic run_random(input int n, input int idle_pct, input int stall_pct,
                             input int hold_at);
      logic [gha_pkg::CMD_W-1:0]   c;
      logic [gha_pkg::INDEX_W-1:0] i;
      logic [gha_pkg::GEN_W-1:0]   g;
      int                          r;
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      for (int k = 0; k < n; k++) begin
         if (k == hold_at)
            hold_reqs++;
         r = $urandom_range(99);
         if (r < 30)      c = gha_pkg::CMD_CREATE;
         else if (r < 60) c = gha_pkg::CMD_DESTROY;
         else if (r < 82) c = gha_pkg::CMD_QUERY;
         else if (r < 88) c = gha_pkg::CMD_BEGIN;
         else if (r < 94) c = gha_pkg::CMD_END;
         else             c = gha_pkg::CMD_W'($urandom_range(CMD_RSVD_FIRST, CMD_RSVD_LAST));
         sb.pick_handle(i, g);
         send_request(c, i, g);
      end
      drain_responses();
   endtask

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("Some tests failed");
      $finish;
   end

   initial begin
      sb = new();
      req_if.valid             <= 1'b0;
      req_if.cmd               <= gha_pkg::CMD_QUERY;
      req_if.handle_index      <= '0;
      req_if.handle_generation <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: fresh create, destroy, stale, reuse, windows, spare codes
      send_request(gha_pkg::CMD_CREATE,  10'd0,   16'd0);
      send_request(gha_pkg::CMD_QUERY,   10'd0,   16'd0);
      send_request(gha_pkg::CMD_DESTROY, 10'd0,   16'd0);
      send_request(gha_pkg::CMD_DESTROY, 10'd0,   16'd0);
      send_request(gha_pkg::CMD_CREATE,  10'd511, 16'hAAAA);
      send_request(gha_pkg::CMD_QUERY,   10'd0,   16'd0);
      send_request(gha_pkg::CMD_CREATE,  '1,      '1);
      send_request(gha_pkg::CMD_QUERY,   '1,      '1);
      send_request(gha_pkg::CMD_BEGIN,   '1,      '1);
      send_request(gha_pkg::CMD_BEGIN,   10'd0,   16'd1);
      send_request(gha_pkg::CMD_DESTROY, 10'd0,   16'd1);
      // same handle twice: second entry goes stale during the drain
      send_request(gha_pkg::CMD_DESTROY, 10'd0,   16'd1);
      send_request(gha_pkg::CMD_QUERY,   10'd0,   16'd1);
      send_request(gha_pkg::CMD_CREATE,  10'd0,   16'd0);
      send_request(gha_pkg::CMD_END,     10'd0,   16'd1);
      send_request(gha_pkg::CMD_END,     10'd1,   16'd0);
      send_request(gha_pkg::CMD_CREATE,  10'd0,   16'd0);
      send_request(CMD_RSVD_FIRST, 10'd1, 16'd0);
      send_request(CMD_RSVD_FIRST + 3'd1, '1, '1);
      send_request(CMD_RSVD_LAST, 10'd0, 16'd2);
      send_request(gha_pkg::CMD_DESTROY, '1,      '1);
      send_request(gha_pkg::CMD_QUERY,   10'd2,   16'h5555);
      drain_responses();

      run_random(200, 0, 0, 120);
      run_random(200, 51, 0, -1);
      run_random(200, 0, 51, -1);
      run_random(200, 31, 31, 150);

      // fill the table, then overflow the deferred queue
      send_idle_pct = 0;
      rsp_stall_pct = 10;
      send_request(gha_pkg::CMD_END, 10'd0, 16'd0);
      while (sb.high_water < MAX_ENT || sb.free_top > 0)
         send_request(gha_pkg::CMD_CREATE, gha_pkg::INDEX_W'($urandom),
                      gha_pkg::GEN_W'($urandom));
      send_request(gha_pkg::CMD_CREATE, '1, '1);
      send_request(gha_pkg::CMD_CREATE, 10'd5, sb.gen_tab[5]);
      send_request(gha_pkg::CMD_QUERY, '1, sb.gen_tab[MAX_ENT-1]);
      send_request(gha_pkg::CMD_BEGIN, 10'd0, 16'd0);
      for (int k = 0; k < PEND_DEPTH + 6; k++)
         send_request(gha_pkg::CMD_DESTROY, gha_pkg::INDEX_W'(k), sb.gen_tab[k]);
      send_request(gha_pkg::CMD_CREATE, 10'd0, 16'd0);
      send_request(gha_pkg::CMD_END, 10'd0, 16'd0);
      send_request(gha_pkg::CMD_QUERY, 10'd0, sb.gen_tab[0]);
      drain_responses();

      run_random(60, 31, 31, -1);

      repeat (20) @(posedge clock);
      if (sb.bad_answers == 0 && sb.awaited_answers.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

/* filelist.f */
+incdir+hdl
hdl/gha_pkg.sv
hdl/gha_req_if.sv
hdl/gha_rsp_if.sv
hdl/gha_entity_table.sv
hdl/generational_handle_allocator.sv
hdl/gha_checker.sv
tb/tb_top.sv
